// ===== hdl/msplit_pkg.sv =====
package msplit_pkg;

    // Operation codes carried on the input channel
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Configuration register indexes
    localparam logic CFG_FULL_SPAN   = 1'b0;
    localparam logic CFG_FLOOR_VALUE = 1'b1;

    // Field widths and span limits
    localparam int VALUE_W  = 7;
    localparam int SPAN_N   = 128;
    localparam logic [VALUE_W-1:0] SPAN_TOP = 7'd127;

    // Default map size
    localparam int NUM_VALUES_DEF = 128;

    // Reset values of the configuration registers
    localparam logic FULL_SPAN_RST   = 1'b1;
    localparam logic FLOOR_VALUE_RST = 1'b0;

    // Command from the front end to the presence map
    typedef struct packed {
        logic               clear;
        logic               set;
        logic [VALUE_W-1:0] idx;
    } t_map_cmd;

    // One lookup result
    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] zone_low;
        logic [VALUE_W-1:0] zone_high;
    } t_zone_res;

endpackage

// ===== hdl/msplit_map.sv =====
module msplit_map #(
    parameter int MAP_BITS = msplit_pkg::SPAN_N
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msplit_pkg::t_map_cmd i_cmd,
    output logic [MAP_BITS-1:0]  o_map
);

    logic [MAP_BITS-1:0] r_map;
    logic [MAP_BITS-1:0] n_map;

    // Clear empties the set; insert sets one bit, values past the map are dropped
    always_comb begin
        n_map = r_map;
        if (i_cmd.clear) begin
            n_map = '0;
        end else if (i_cmd.set) begin
            for (int i = 0; i < MAP_BITS; i++) begin
                if (i_cmd.idx == msplit_pkg::VALUE_W'(i)) begin
                    n_map[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else begin
            r_map <= n_map;
        end
    end

    assign o_map = r_map;

endmodule

// ===== hdl/msplit_zone.sv =====
module msplit_zone (
    input  logic [msplit_pkg::SPAN_N-1:0]  i_map,
    input  logic [msplit_pkg::VALUE_W-1:0] i_value,
    input  logic                           i_full_span,
    input  logic                           i_floor_value,
    output msplit_pkg::t_zone_res          o_res
);

    localparam int W = msplit_pkg::VALUE_W;
    localparam int N = msplit_pkg::SPAN_N;

    logic [N-1:0] below_mask;
    logic [N-1:0] above_mask;
    logic [N-1:0] below;
    logic [N-1:0] above;
    logic         has_prev;
    logic         has_next;
    logic [W-1:0] prev;
    logic [W-1:0] next;
    logic [W:0]   lo_raw;
    logic [W:0]   hi_raw;
    logic [W:0]   floor_ext;
    logic [W:0]   lo_clamp;
    logic [W:0]   hi_clamp;
    logic         found;

    // Anchors strictly below and strictly above the value
    assign below_mask = (N'(1) << i_value) - N'(1);
    assign above_mask = ({N{1'b1}} << i_value) << 1;
    assign below      = i_map & below_mask;
    assign above      = i_map & above_mask;
    assign has_prev   = |below;
    assign has_next   = |above;
    assign found      = i_map[i_value];

    // Nearest lower anchor: highest set bit below the value
    always_comb begin
        prev = '0;
        for (int i = 0; i < N; i++) begin
            if (below[i]) begin
                prev = W'(i);
            end
        end
    end

    // Nearest higher anchor: lowest set bit above the value
    always_comb begin
        next = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (above[i]) begin
                next = W'(i);
            end
        end
    end

    // Raw edges from floor midpoints (the lower edge one past its midpoint), or the end rules
    assign floor_ext = {{W{1'b0}}, i_floor_value};

    always_comb begin
        if (has_prev) begin
            lo_raw = ((({1'b0, prev}) + ({1'b0, i_value})) >> 1) + (W+1)'(1);
        end else if (i_full_span) begin
            lo_raw = floor_ext;
        end else begin
            lo_raw = {1'b0, i_value};
        end

        if (has_next) begin
            hi_raw = (({1'b0, i_value}) + ({1'b0, next})) >> 1;
        end else if (i_full_span) begin
            hi_raw = {1'b0, msplit_pkg::SPAN_TOP};
        end else begin
            hi_raw = {1'b0, i_value};
        end
    end

    // Clamp to [floor, top]
    always_comb begin
        priority if (lo_raw < floor_ext) begin
            lo_clamp = floor_ext;
        end else if (lo_raw > {1'b0, msplit_pkg::SPAN_TOP}) begin
            lo_clamp = {1'b0, msplit_pkg::SPAN_TOP};
        end else begin
            lo_clamp = lo_raw;
        end

        priority if (hi_raw < floor_ext) begin
            hi_clamp = floor_ext;
        end else if (hi_raw > {1'b0, msplit_pkg::SPAN_TOP}) begin
            hi_clamp = {1'b0, msplit_pkg::SPAN_TOP};
        end else begin
            hi_clamp = hi_raw;
        end
    end

    // Order the edges; absent values report zeros
    always_comb begin
        o_res.found = found;
        if (!found) begin
            o_res.zone_low  = '0;
            o_res.zone_high = '0;
        end else if (lo_clamp > hi_clamp) begin
            o_res.zone_low  = hi_clamp[W-1:0];
            o_res.zone_high = lo_clamp[W-1:0];
        end else begin
            o_res.zone_low  = lo_clamp[W-1:0];
            o_res.zone_high = hi_clamp[W-1:0];
        end
    end

endmodule

// ===== hdl/midpoint_range_splitter_top.sv =====
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_opcode, i_value
// out       output     o_out_valid / i_out_stall o_found, o_zone_low, o_zone_high
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_stall is low. A lookup waits in the input register while the
// encoders find its neighbors, then loads the result register once the result channel can
// take it, and transfers out from there.
// Clear and insert update the map at their transfer edge; they produce no result.
// Reset (synchronous, active low) empties the map, sets full_span=1, floor_value=0.
// Input stalls only while a lookup waits behind a stalled result.
module midpoint_range_splitter_top #(
    parameter int NUM_VALUES = msplit_pkg::NUM_VALUES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [msplit_pkg::VALUE_W-1:0] i_value,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_found,
    output logic [msplit_pkg::VALUE_W-1:0] o_zone_low,
    output logic [msplit_pkg::VALUE_W-1:0] o_zone_high,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic                           i_cfg_data
);

    localparam int W        = msplit_pkg::VALUE_W;
    localparam int N        = msplit_pkg::SPAN_N;
    localparam int MAP_BITS = (NUM_VALUES < N) ? NUM_VALUES : N;

    logic                  r_full_span;
    logic                  r_floor_value;
    logic                  r_s1_valid;
    logic [W-1:0]          r_s1_value;
    logic                  r_out_valid;
    msplit_pkg::t_zone_res r_out;

    logic                  in_xfer;
    logic                  s1_advance;
    logic                  cfg_xfer;
    msplit_pkg::t_map_cmd  map_cmd;
    logic [MAP_BITS-1:0]   map_bits;
    logic [N-1:0]          map_full;
    msplit_pkg::t_zone_res zone_res;

    // Handshakes
    assign s1_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !s1_advance;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // Map commands take effect at the transfer edge
    always_comb begin
        map_cmd.clear = in_xfer && (i_opcode == msplit_pkg::OP_CLEAR);
        map_cmd.set   = in_xfer && (i_opcode == msplit_pkg::OP_INSERT);
        map_cmd.idx   = i_value;
    end

    msplit_map #(
        .MAP_BITS (MAP_BITS)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (map_cmd),
        .o_map   (map_bits)
    );

    // Bits past the map read as absent
    assign map_full = N'(map_bits);

    msplit_zone u_zone (
        .i_map         (map_full),
        .i_value       (r_s1_value),
        .i_full_span   (r_full_span),
        .i_floor_value (r_floor_value),
        .o_res         (zone_res)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_span   <= msplit_pkg::FULL_SPAN_RST;
            r_floor_value <= msplit_pkg::FLOOR_VALUE_RST;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                msplit_pkg::CFG_FULL_SPAN:   r_full_span   <= i_cfg_data;
                msplit_pkg::CFG_FLOOR_VALUE: r_floor_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: holds a pending lookup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            if (s1_advance || !r_s1_valid) begin
                r_s1_valid <= in_xfer && (i_opcode == msplit_pkg::OP_LOOKUP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_opcode == msplit_pkg::OP_LOOKUP)) begin
            r_s1_value <= i_value;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out <= zone_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out.found;
    assign o_zone_low  = r_out.zone_low;
    assign o_zone_high = r_out.zone_high;

endmodule
